### design/i2cwps_pkg.sv
`timescale 1ns / 1ps

package i2cwps_pkg;

    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned HoldWidth  = 3;
    localparam int unsigned CountWidth = 4;

    // Index of the last phase of each segment.
    localparam logic [CountWidth-1:0] StopLast  = 4'd4;
    localparam logic [CountWidth-1:0] StartLast = 4'd2;
    localparam logic [CountWidth-1:0] BitsLast  = 4'd15;
    localparam logic [CountWidth-1:0] AckLast   = 4'd3;

    localparam logic [HoldWidth-1:0] HoldShort = 3'd1;
    localparam logic [HoldWidth-1:0] HoldLong  = 3'd6;

    // The controller state also names the segment of the phase run being emitted.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE_STOP,
        ST_START,
        ST_BITS,
        ST_ACK,
        ST_POST_STOP
    } state_t;

    typedef struct packed {
        logic   load;
        logic   emit;
        logic   last;
        state_t seg;
    } ctrl_cmd_t;

    typedef struct packed {
        logic opens;
        logic closes;
        logic seg_end;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic                 ack_sample;
        logic [HoldWidth-1:0] hold_units;
        logic                 data_drive;
        logic                 data_level;
        logic                 clock_level;
    } phase_t;

    function automatic phase_t make_phase(logic clk, logic lvl, logic drv,
                                          logic [HoldWidth-1:0] hold, logic sample);
        phase_t p;
        p.clock_level = clk;
        p.data_level  = drv & lvl;
        p.data_drive  = drv;
        p.hold_units  = hold;
        p.ack_sample  = sample;
        return p;
    endfunction

    // Phase for a given segment, position in it, and current top bit of the byte.
    function automatic phase_t phase_of(state_t seg, logic [CountWidth-1:0] idx,
                                        logic bit_value);
        phase_t p;
        p = make_phase(1'b0, 1'b0, 1'b0, HoldShort, 1'b0);
        case (seg)
            ST_PRE_STOP, ST_POST_STOP: begin
                case (idx)
                    4'd0: p = make_phase(1'b0, 1'b0, 1'b0, HoldShort, 1'b0);
                    4'd1: p = make_phase(1'b0, 1'b0, 1'b1, HoldShort, 1'b0);
                    4'd2: p = make_phase(1'b1, 1'b0, 1'b1, HoldShort, 1'b0);
                    4'd3: p = make_phase(1'b1, 1'b1, 1'b1, HoldShort, 1'b0);
                    default: p = make_phase(1'b1, 1'b0, 1'b0, HoldLong, 1'b0);
                endcase
            end
            ST_START: begin
                case (idx)
                    4'd0: p = make_phase(1'b1, 1'b1, 1'b1, HoldShort, 1'b0);
                    4'd1: p = make_phase(1'b1, 1'b0, 1'b1, HoldShort, 1'b0);
                    default: p = make_phase(1'b0, 1'b0, 1'b1, HoldShort, 1'b0);
                endcase
            end
            ST_BITS: begin
                p = make_phase(idx[0], bit_value, 1'b1, HoldShort, 1'b0);
            end
            ST_ACK: begin
                p = make_phase((idx == 4'd1) || (idx == 4'd2), 1'b0, 1'b0, HoldShort,
                               idx == 4'd1);
            end
            default: begin
                p = make_phase(1'b0, 1'b0, 1'b0, HoldShort, 1'b0);
            end
        endcase
        return p;
    endfunction

endpackage

### design/i2cwps_ctrl.sv
`timescale 1ns / 1ps

module i2cwps_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  i2cwps_pkg::dp_status_t status,
    output i2cwps_pkg::ctrl_cmd_t  cmd
);

    i2cwps_pkg::state_t state_reg;
    i2cwps_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2cwps_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.last   = 1'b0;
        cmd.seg    = state_reg;
        case (state_reg)
            i2cwps_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = status.opens ? i2cwps_pkg::ST_PRE_STOP
                                              : i2cwps_pkg::ST_BITS;
                end
            end
            i2cwps_pkg::ST_PRE_STOP: begin
                cmd.emit = status.out_free;
                if (status.out_free && status.seg_end) begin
                    state_next = i2cwps_pkg::ST_START;
                end
            end
            i2cwps_pkg::ST_START: begin
                cmd.emit = status.out_free;
                if (status.out_free && status.seg_end) begin
                    state_next = i2cwps_pkg::ST_BITS;
                end
            end
            i2cwps_pkg::ST_BITS: begin
                cmd.emit = status.out_free;
                if (status.out_free && status.seg_end) begin
                    state_next = i2cwps_pkg::ST_ACK;
                end
            end
            i2cwps_pkg::ST_ACK: begin
                cmd.emit = status.out_free;
                cmd.last = status.seg_end && !status.closes;
                if (status.out_free && status.seg_end) begin
                    state_next = status.closes ? i2cwps_pkg::ST_POST_STOP
                                               : i2cwps_pkg::ST_IDLE;
                end
            end
            i2cwps_pkg::ST_POST_STOP: begin
                cmd.emit = status.out_free;
                cmd.last = status.seg_end;
                if (status.out_free && status.seg_end) begin
                    state_next = i2cwps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = i2cwps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/i2cwps_dp.sv
`timescale 1ns / 1ps

module i2cwps_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [i2cwps_pkg::ByteWidth-1:0]     byte_value,
    input  logic                                 opens_transaction,
    input  logic                                 closes_transaction,
    input  i2cwps_pkg::ctrl_cmd_t                cmd,
    output i2cwps_pkg::dp_status_t               status,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output i2cwps_pkg::phase_t                   m_phase,
    output logic                                 m_last
);

    logic [i2cwps_pkg::ByteWidth-1:0]  shift_reg;
    logic                              close_reg;
    logic [i2cwps_pkg::CountWidth-1:0] count_reg;
    logic                              valid_reg;
    i2cwps_pkg::phase_t                phase_reg;
    logic                              last_reg;
    logic [i2cwps_pkg::CountWidth-1:0] seg_last;

    always_comb begin
        case (cmd.seg)
            i2cwps_pkg::ST_PRE_STOP, i2cwps_pkg::ST_POST_STOP: seg_last = i2cwps_pkg::StopLast;
            i2cwps_pkg::ST_START: seg_last = i2cwps_pkg::StartLast;
            i2cwps_pkg::ST_BITS:  seg_last = i2cwps_pkg::BitsLast;
            i2cwps_pkg::ST_ACK:   seg_last = i2cwps_pkg::AckLast;
            default:              seg_last = '0;
        endcase
    end

    // The opening marker is only consulted in the cycle the byte is taken.
    assign status.opens    = opens_transaction;
    assign status.closes   = close_reg;
    assign status.seg_end  = (count_reg == seg_last);
    assign status.out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
            close_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                close_reg <= closes_transaction;
                count_reg <= '0;
            end else if (cmd.emit) begin
                count_reg <= status.seg_end ? '0 : count_reg + 1'b1;
            end
            if (cmd.emit) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            shift_reg <= byte_value;
        end else if (cmd.emit && (cmd.seg == i2cwps_pkg::ST_BITS) && count_reg[0]) begin
            shift_reg <= {shift_reg[i2cwps_pkg::ByteWidth-2:0], 1'b0};
        end
        if (cmd.emit) begin
            phase_reg <= i2cwps_pkg::phase_of(cmd.seg, count_reg,
                                               shift_reg[i2cwps_pkg::ByteWidth-1]);
            last_reg  <= cmd.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_phase  = phase_reg;
    assign m_last   = last_reg;

endmodule

### design/i2c_write_phase_sequencer.sv
`timescale 1ns / 1ps
// After a byte is taken in idle, its first bus phase is formed and held in the output register.
// Throughput: 20, 25, 28 or 33 phases per byte, one per cycle while m_tready is high; the next
// byte is taken in idle only after the last phase of the current one has been emitted.
// Reset: synchronous active-low aresetn returns the controller to idle and empties the
// output register; the byte and phase-count registers are reloaded on every byte.

module i2c_write_phase_sequencer (
    input  logic       aclk,
    input  logic       aresetn,
    // Input byte channel.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic [1:0] s_tuser,   // [0] opens_transaction, [1] closes_transaction
    // Bus phase channel.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] clock_level, [1] data_level, [2] data_drive,
                                  // [5:3] hold_units, [6] ack_sample, [7] zero
    output logic       m_tlast    // last_phase
);

    i2cwps_pkg::ctrl_cmd_t  cmd;
    i2cwps_pkg::dp_status_t status;
    i2cwps_pkg::phase_t     phase;

    // The controller walks the segments of a byte's phase run: an optional stop and
    // start, sixteen bit phases, four acknowledge phases, and an optional closing stop.
    i2cwps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the byte, its closing marker, the position within the current
    // segment and the output register that parts the two channels.
    i2cwps_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .byte_value         (s_tdata),
        .opens_transaction  (s_tuser[0]),
        .closes_transaction (s_tuser[1]),
        .cmd                (cmd),
        .status             (status),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_phase            (phase),
        .m_last             (m_tlast)
    );

    assign m_tdata = {1'b0, phase.ack_sample, phase.hold_units, phase.data_drive,
                      phase.data_level, phase.clock_level};

endmodule
